// ===== rtl/tisu_pkg.sv =====
// Shared types and codes of the timed interrupt slot unit.
// Used by the slot cell, the top level and the checker.
package tisu_pkg;

    // Command codes carried in the request.
    localparam logic [2:0] CMD_ALLOC = 3'd0;
    localparam logic [2:0] CMD_FREE  = 3'd1;
    localparam logic [2:0] CMD_SET   = 3'd2;
    localparam logic [2:0] CMD_CHECK = 3'd3;
    localparam logic [2:0] CMD_CLAMP = 3'd4;

    // Status codes carried in the response.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

    localparam logic [63:0] ALL_ONES = '1;

    // Running record that walks down the row of slot cells, one cell per cycle.
    typedef struct packed {
        logic        valid;
        logic        alloc_done;
        logic [1:0]  status;
        logic [3:0]  granted;
        logic [15:0] fired;
        logic [63:0] least;
    } t_carry;

endpackage

// ===== rtl/tisu_if.sv =====
// Request and response channel interfaces of the timed interrupt slot unit.
// Depends on nothing; the payload fields follow the request and response formats.
interface tisu_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [3:0]  slot;
    logic [63:0] deadline_us;
    logic [63:0] now_us;
    logic [63:0] sleep_us;

    modport source (output valid, command, slot, deadline_us, now_us, sleep_us,
                    input ready);
    modport sink   (input valid, command, slot, deadline_us, now_us, sleep_us,
                    output ready);
endinterface

interface tisu_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  granted_slot;
    logic [15:0] fired_mask;
    logic [63:0] next_deadline_us;
    logic [63:0] clamped_sleep_us;

    modport source (output valid, status, granted_slot, fired_mask, next_deadline_us,
                    clamped_sleep_us, input ready);
    modport sink   (input valid, status, granted_slot, fired_mask, next_deadline_us,
                    clamped_sleep_us, output ready);
endinterface

// ===== rtl/tisu_cell.sv =====
// One timer slot: busy bit and 64-bit deadline, plus its stage of the running record.
// Depends on tisu_pkg for the command codes and the carry record.
module tisu_cell #(
    parameter int INDEX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [2:0]      i_command,
    input  logic [3:0]      i_slot,
    input  logic [63:0]     i_deadline_us,
    input  logic [63:0]     i_now_us,
    input  tisu_pkg::t_carry i_carry,
    output tisu_pkg::t_carry o_carry
);

    // Fired bit of this slot; slots above fifteen have none.
    localparam logic [15:0] FireBit = 16'(32'd1 << INDEX);

    logic            r_busy;
    logic [63:0]     r_deadline;
    tisu_pkg::t_carry r_carry;

    logic            n_busy;
    logic [63:0]     n_deadline;
    tisu_pkg::t_carry n_carry;
    logic            w_hit;

    assign w_hit = ({28'd0, i_slot} == 32'(INDEX));

    // Apply the command to this slot, then fold the updated slot into the record.
    always_comb begin
        n_busy     = r_busy;
        n_deadline = r_deadline;
        n_carry    = i_carry;
        case (i_command)
            tisu_pkg::CMD_ALLOC: begin
                if (!i_carry.alloc_done && !r_busy) begin
                    n_busy             = 1'b1;
                    n_carry.alloc_done = 1'b1;
                    n_carry.granted    = 4'(INDEX);
                    n_carry.status     = tisu_pkg::ST_OK;
                end
            end
            tisu_pkg::CMD_FREE: begin
                if (w_hit && r_busy) begin
                    n_busy         = 1'b0;
                    n_carry.status = tisu_pkg::ST_OK;
                end
            end
            tisu_pkg::CMD_SET: begin
                if (w_hit) begin
                    n_deadline = i_deadline_us;
                end
            end
            tisu_pkg::CMD_CHECK: begin
                if (r_busy && (r_deadline < i_now_us)) begin
                    n_carry.fired = i_carry.fired | FireBit;
                end
            end
            default: begin
            end
        endcase
        if (n_busy && (n_deadline < i_carry.least)) begin
            n_carry.least = n_deadline;
        end
    end

    // The slot only changes while the record is passing through it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_deadline    <= '0;
            r_carry.valid <= 1'b0;
        end else begin
            r_carry <= n_carry;
            if (i_carry.valid) begin
                r_busy     <= n_busy;
                r_deadline <= n_deadline;
            end
        end
    end

    assign o_carry = r_carry;

endmodule

// ===== rtl/timed_interrupt_slot_unit.sv =====
// Top level of the timed interrupt slot unit: request register, row of slot cells,
// clamp arithmetic and response register. Depends on tisu_pkg, tisu_if and tisu_cell.
//
// A record walks the row of slot cells one cell per cycle, updating the slot state
// and gathering the least active deadline and the fired mask. The record is then
// captured, the clamp intermediates are registered, and the clamped sleep is loaded
// into the response register. One request is in flight at a time, so a new request
// is taken only once the previous one has loaded its response. Ready is high whenever
// no request is being worked on, also while an earlier response still waits to be
// taken. A finished request waits in its last step until the previous response has
// been taken.
module timed_interrupt_slot_unit #(
    parameter int NUM_SLOTS = 16
) (
    input logic         i_clk,
    input logic         i_rst_n,
    tisu_req_if.sink    i_req,
    tisu_rsp_if.source  o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_DONE
    } t_state;

    t_state r_state;

    // Request held steady for the cells during the walk.
    logic [2:0]  r_command;
    logic [3:0]  r_slot;
    logic [63:0] r_deadline;
    logic [63:0] r_now;
    logic [63:0] r_sleep;
    logic [63:0] r_expiry;

    // Record results and clamp intermediates.
    logic [1:0]  r_status;
    logic [3:0]  r_granted;
    logic [15:0] r_fired;
    logic [63:0] r_least;
    logic [63:0] r_diff;
    logic        r_use_sleep;

    // Response register.
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [3:0]  r_out_granted;
    logic [15:0] r_out_fired;
    logic [63:0] r_out_next;
    logic [63:0] r_out_clamped;

    tisu_pkg::t_carry r_start;
    tisu_pkg::t_carry n_start;
    tisu_pkg::t_carry w_carry [NUM_SLOTS+1];
    logic [63:0]      n_clamped;
    logic             w_load;

    // Starting record: allocation fails and freeing errs unless some cell clears it.
    always_comb begin
        n_start.valid      = (r_state == S_IDLE) && i_req.valid;
        n_start.alloc_done = 1'b0;
        n_start.granted    = '0;
        n_start.fired      = '0;
        n_start.least      = tisu_pkg::ALL_ONES;
        case (i_req.command)
            tisu_pkg::CMD_ALLOC: n_start.status = tisu_pkg::ST_FULL;
            tisu_pkg::CMD_FREE:  n_start.status = tisu_pkg::ST_NOT_ALLOC;
            default:             n_start.status = tisu_pkg::ST_OK;
        endcase
    end

    assign w_carry[0] = r_start;

    // Row of slot cells.
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        tisu_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_command     (r_command),
            .i_slot        (r_slot),
            .i_deadline_us (r_deadline),
            .i_now_us      (r_now),
            .i_carry       (w_carry[g]),
            .o_carry       (w_carry[g+1])
        );
    end

    // Clamped sleep for CMD_CLAMP, else zero: the sleep, or three quarters of the distance to an earlier deadline.
    always_comb begin
        if (r_command != tisu_pkg::CMD_CLAMP) begin
            n_clamped = '0;
        end else if (r_use_sleep) begin
            n_clamped = r_sleep;
        end else begin
            n_clamped = (r_diff >> 2) + (r_diff >> 1);
        end
    end

    // The response register loads once the previous response is gone or leaving.
    assign w_load = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // Sequencer, request register and response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_start.valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_start <= n_start;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_command  <= i_req.command;
                        r_slot     <= i_req.slot;
                        r_deadline <= i_req.deadline_us;
                        r_now      <= i_req.now_us;
                        r_sleep    <= i_req.sleep_us;
                        r_expiry   <= i_req.now_us + i_req.sleep_us;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_carry[NUM_SLOTS].valid) begin
                        r_status  <= w_carry[NUM_SLOTS].status;
                        r_granted <= w_carry[NUM_SLOTS].granted;
                        r_fired   <= w_carry[NUM_SLOTS].fired;
                        r_least   <= w_carry[NUM_SLOTS].least;
                        r_state   <= S_CALC;
                    end
                end
                S_CALC: begin
                    // The sleep stands unless an active deadline falls before expiry.
                    r_use_sleep <= !(r_least < r_expiry);
                    r_diff      <= r_least - r_now;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (w_load) begin
                        r_out_status  <= r_status;
                        r_out_granted <= r_granted;
                        r_out_fired   <= r_fired;
                        r_out_next    <= r_least;
                        r_out_clamped <= n_clamped;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready            = (r_state == S_IDLE);
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_out_status;
    assign o_rsp.granted_slot     = r_out_granted;
    assign o_rsp.fired_mask       = r_out_fired;
    assign o_rsp.next_deadline_us = r_out_next;
    assign o_rsp.clamped_sleep_us = r_out_clamped;

endmodule

// ===== rtl/tisu_checker.sv =====
// Port-level checks on the timed interrupt slot unit, bound to its top level.
// Depends on tisu_pkg for the status codes and the all-ones deadline.
module tisu_sva_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_status,
    input logic [3:0]  i_granted,
    input logic [15:0] i_fired,
    input logic [63:0] i_next
);

    // A request occupies the unit, so the next cycle cannot take another.
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while one is in flight");

    // A fired slot is an active slot, so some deadline must be reported.
    a_fired_has_deadline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_fired != 16'd0)) |-> (i_next != tisu_pkg::ALL_ONES))
        else $error("fired mask set with no active slot");

    // Failed requests grant nothing and fire nothing.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && ((i_status == tisu_pkg::ST_FULL) ||
                         (i_status == tisu_pkg::ST_NOT_ALLOC)))
        |-> ((i_granted == 4'd0) && (i_fired == 16'd0)))
        else $error("error response carries a grant or fired bits");

    // A response that is not taken stays offered.
    a_rsp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("response dropped before it was taken");

endmodule

bind timed_interrupt_slot_unit tisu_sva_checker u_tisu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_granted   (o_rsp.granted_slot),
    .i_fired     (o_rsp.fired_mask),
    .i_next      (o_rsp.next_deadline_us)
);
